// ===== rtl/sstf_pkg.sv =====
package sstf_pkg;

  localparam int TRACK_W         = 16;
  localparam int SUM_W           = 22;
  localparam int COUNT_W         = 7;
  localparam int DEF_MAX_PENDING = 64;
  localparam int DEF_TRACK_BITS  = 16;

  localparam logic [SUM_W-1:0] TOTAL_MAX = {SUM_W{1'b1}};

  // commands broadcast from the sequencer to every cell
  typedef struct packed {
    logic load;
    logic serve;
    logic clear;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_RESULT
  } state_t;

endpackage

// ===== rtl/sstf_cell.sv =====
module sstf_cell import sstf_pkg::*; #(
  parameter int TRACK_BITS = DEF_TRACK_BITS,
  parameter int IDX_W      = 6,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_cmd_t             cmd,
  input  logic [IDX_W-1:0]      cmd_idx,
  input  logic [TRACK_BITS-1:0] load_track,
  input  logic [TRACK_BITS-1:0] head,
  input  logic                  in_vld,
  input  logic                  in_found,
  input  logic [TRACK_BITS-1:0] in_d,
  input  logic [IDX_W-1:0]      in_idx,
  input  logic [TRACK_BITS-1:0] in_trk,
  output logic                  out_vld,
  output logic                  out_found,
  output logic [TRACK_BITS-1:0] out_d,
  output logic [IDX_W-1:0]      out_idx,
  output logic [TRACK_BITS-1:0] out_trk
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [TRACK_BITS-1:0] trk;
  logic                  stored;
  logic                  served;
  logic                  hit;
  logic [TRACK_BITS-1:0] d;
  logic                  take;

  assign hit = (cmd_idx == MY_IDX);
  assign d   = (trk >= head) ? (trk - head) : (head - trk);
  // strict compare keeps the earlier cell on a tie
  assign take = in_vld && stored && !served && (!in_found || (d < in_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= 1'b0;
      served <= 1'b0;
    end else if (cmd.clear) begin
      stored <= 1'b0;
      served <= 1'b0;
    end else begin
      if (cmd.load && hit) begin
        stored <= 1'b1;
      end
      if (cmd.serve && hit) begin
        served <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && hit) begin
      trk <= load_track;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_found <= in_found || take;
    if (take) begin
      out_d   <= d;
      out_idx <= MY_IDX;
      out_trk <= trk;
    end else begin
      out_d   <= in_d;
      out_idx <= in_idx;
      out_trk <= in_trk;
    end
  end

endmodule

// ===== rtl/sstf_disk_scheduler_unit.sv =====
// Shortest-seek-first disk scheduler. Requests are taken one item per cycle while the unit
// is idle into a row of MAX_PENDING cells; an item with last set closes the batch (requests
// past capacity are dropped and reported in overflow). The head starts at start_track and
// each service step sends a search token down the cell row, one cell per cycle, picking the
// nearest unserved request (earliest loaded on a tie). A step ends when the token leaves the
// last cell; once every stored request is served, the batch result is ready for the output
// register. No new item is taken until that result has moved into the output register.
module sstf_disk_scheduler_unit import sstf_pkg::*; #(
  parameter int MAX_PENDING = DEF_MAX_PENDING,
  parameter int TRACK_BITS  = DEF_TRACK_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TRACK_W-1:0] start_track,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TRACK_W-1:0] track,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SUM_W-1:0]   total_movement,
  output logic [COUNT_W-1:0] request_count,
  output logic               overflow
);

  localparam int IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
  localparam int CNT_W = $clog2(MAX_PENDING + 1);
  localparam int ACC_W = ((TRACK_BITS > SUM_W) ? TRACK_BITS : SUM_W) + 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_PENDING);

  state_t state, state_next;

  logic [TRACK_W-1:0]    start_reg;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      left;
  logic                  dropped;
  logic [TRACK_BITS-1:0] head;
  logic [SUM_W-1:0]      sum;

  cell_cmd_t             cmd;
  logic [IDX_W-1:0]      cmd_idx;
  logic                  launch;
  logic                  take_result;
  logic                  in_acc;
  logic                  has_room;
  logic [CNT_W-1:0]      count_after;
  logic [ACC_W-1:0]      acc;
  logic [SUM_W-1:0]      sum_next;

  logic                  ch_vld   [MAX_PENDING+1];
  logic                  ch_found [MAX_PENDING+1];
  logic [TRACK_BITS-1:0] ch_d     [MAX_PENDING+1];
  logic [IDX_W-1:0]      ch_idx   [MAX_PENDING+1];
  logic [TRACK_BITS-1:0] ch_trk   [MAX_PENDING+1];

  logic                  end_vld;
  logic                  end_found;
  logic [TRACK_BITS-1:0] end_d;
  logic [IDX_W-1:0]      end_idx;
  logic [TRACK_BITS-1:0] end_trk;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_reg <= start_track;
    end
  end

  assign in_acc      = in_valid && in_ready;
  assign has_room    = (count < FULL);
  assign count_after = has_room ? (count + CNT_W'(1)) : count;

  // token enters the row empty
  assign ch_vld[0]   = launch;
  assign ch_found[0] = 1'b0;
  assign ch_d[0]     = '0;
  assign ch_idx[0]   = '0;
  assign ch_trk[0]   = '0;

  assign cmd_idx = cmd.serve ? end_idx : count[IDX_W-1:0];

  for (genvar i = 0; i < MAX_PENDING; i++) begin : g_cell
    sstf_cell #(
      .TRACK_BITS(TRACK_BITS),
      .IDX_W     (IDX_W),
      .CELL_IDX  (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .cmd_idx   (cmd_idx),
      .load_track(TRACK_BITS'(track)),
      .head      (head),
      .in_vld    (ch_vld[i]),
      .in_found  (ch_found[i]),
      .in_d      (ch_d[i]),
      .in_idx    (ch_idx[i]),
      .in_trk    (ch_trk[i]),
      .out_vld   (ch_vld[i+1]),
      .out_found (ch_found[i+1]),
      .out_d     (ch_d[i+1]),
      .out_idx   (ch_idx[i+1]),
      .out_trk   (ch_trk[i+1])
    );
  end

  assign end_vld   = ch_vld[MAX_PENDING];
  assign end_found = ch_found[MAX_PENDING];
  assign end_d     = ch_d[MAX_PENDING];
  assign end_idx   = ch_idx[MAX_PENDING];
  assign end_trk   = ch_trk[MAX_PENDING];

  // saturating running sum
  assign acc      = ACC_W'(sum) + ACC_W'(end_d);
  assign sum_next = (acc > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX : acc[SUM_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && last) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (end_vld) begin
          state_next = (left == CNT_W'(1)) ? ST_RESULT : ST_LAUNCH;
        end
      end
      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    launch      = 1'b0;
    take_result = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid && has_room;
      end
      ST_LAUNCH: begin
        launch = 1'b1;
      end
      ST_SCAN: begin
        cmd.serve = end_vld;
      end
      ST_RESULT: begin
        take_result = !out_valid || out_ready;
        cmd.clear   = take_result;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      left    <= '0;
      head    <= '0;
      sum     <= '0;
    end else begin
      if (in_acc) begin
        count <= count_after;
        if (!has_room) begin
          dropped <= 1'b1;
        end
        if (last) begin
          head <= TRACK_BITS'(start_reg);
          sum  <= '0;
          left <= count_after;
        end
      end else if (cmd.serve) begin
        head <= end_trk;
        sum  <= sum_next;
        left <= left - CNT_W'(1);
      end else if (take_result) begin
        count   <= '0;
        dropped <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_result) begin
      total_movement <= sum;
      request_count  <= COUNT_W'(count);
      overflow       <= dropped;
    end
  end

  a_token_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    end_vld |-> (state == ST_SCAN))
    else $error("search token left the row outside a scan");

  a_token_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && end_vld) |-> end_found)
    else $error("scan ended with no unserved request");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("stored count beyond capacity");

  a_scan_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_LAUNCH) |-> (left != '0))
    else $error("scan running with nothing left to serve");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_RESULT))
    else $error("result appeared without a finished batch");

endmodule

// ===== bench/sstf_seek_checker.sv =====
module sstf_seek_checker import sstf_pkg::*; #(
  parameter int MAX_PENDING = DEF_MAX_PENDING
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [TRACK_W-1:0] start_track,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [TRACK_W-1:0] track,
  input  logic               last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [SUM_W-1:0]   total_movement,
  input  logic [COUNT_W-1:0] request_count,
  input  logic               overflow,
  output int                 fails,
  output int                 pending
);

  typedef struct packed {
    logic [SUM_W-1:0]   movement;
    logic [COUNT_W-1:0] count;
    logic               dropped;
  } seek_result_t;

  logic [TRACK_W-1:0] head_start;
  logic [TRACK_W-1:0] req_tracks [MAX_PENDING];
  int                 n_stored;
  logic               dropped;
  seek_result_t       expected_seeks [$];

  // nearest unserved request each step, earliest stored wins a tie
  function automatic seek_result_t seek_total();
    logic [MAX_PENDING-1:0] served;
    logic [TRACK_W-1:0]     head;
    int                     best;
    int unsigned            best_d;
    int unsigned            step_d;
    longint unsigned        acc;
    int                     k;
    int                     i;
    seek_result_t           r;
    served = '0;
    head   = head_start;
    acc    = 0;
    for (k = 0; k < n_stored; k++) begin
      best   = -1;
      best_d = 0;
      for (i = 0; i < n_stored; i++) begin
        if (!served[i]) begin
          step_d = (req_tracks[i] >= head) ? req_tracks[i] - head : head - req_tracks[i];
          if (best < 0 || step_d < best_d) begin
            best   = i;
            best_d = step_d;
          end
        end
      end
      served[best] = 1'b1;
      acc += best_d;
      if (acc > TOTAL_MAX) acc = TOTAL_MAX;
      head = req_tracks[best];
    end
    r.movement = acc[SUM_W-1:0];
    r.count    = COUNT_W'(n_stored);
    r.dropped  = dropped;
    return r;
  endfunction

  always @(posedge clk) begin
    seek_result_t want;
    if (rst) begin
      head_start = '0;
      n_stored   = 0;
      dropped    = 1'b0;
      fails      = 0;
      expected_seeks.delete();
    end else begin
      if (cfg_valid && cfg_ready) head_start = start_track;
      if (in_valid && in_ready) begin
        if (n_stored < MAX_PENDING) begin
          req_tracks[n_stored] = track;
          n_stored++;
        end else begin
          dropped = 1'b1;
        end
        if (last) begin
          expected_seeks.push_back(seek_total());
          n_stored = 0;
          dropped  = 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_seeks.size() == 0) begin
          $error("result with nothing expected: total_movement %0d", total_movement);
          fails++;
        end else begin
          want = expected_seeks.pop_front();
          if (total_movement !== want.movement) begin
            $error("total_movement: expected %0d, got %0d", want.movement, total_movement);
            fails++;
          end
          if (request_count !== want.count) begin
            $error("request_count: expected %0d, got %0d", want.count, request_count);
            fails++;
          end
          if (overflow !== want.dropped) begin
            $error("overflow: expected %0d, got %0d", want.dropped, overflow);
            fails++;
          end
        end
      end
    end
    pending <= expected_seeks.size();
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  import sstf_pkg::*;

  localparam int LIMIT   = 50000;
  localparam int N_ITEMS = 1100;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [TRACK_W-1:0] start_track;
  logic               in_valid;
  logic               in_ready;
  logic [TRACK_W-1:0] track;
  logic               last;
  logic               out_valid;
  logic               out_ready;
  logic [SUM_W-1:0]   total_movement;
  logic [COUNT_W-1:0] request_count;
  logic               overflow;

  int fails;
  int pending;
  int idle_cycles = 0;
  int items_sent  = 0;
  bit calm        = 1'b0;
  bit hold_req    = 1'b0;

  sstf_disk_scheduler_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .start_track    (start_track),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .track          (track),
    .last           (last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .total_movement (total_movement),
    .request_count  (request_count),
    .overflow       (overflow)
  );

  sstf_seek_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .start_track    (start_track),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .track          (track),
    .last           (last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .total_movement (total_movement),
    .request_count  (request_count),
    .overflow       (overflow),
    .fails          (fails),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (2000) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [TRACK_W-1:0] t, input logic l);
    int gap;
    if (!calm && $urandom_range(99) < 7) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    track    <= t;
    last     <= l;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // drop valid and wait until every batch result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_start(input logic [TRACK_W-1:0] v);
    cfg_valid   <= 1'b1;
    start_track <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_batch(input int size, input int mode);
    logic [TRACK_W-1:0] t;
    int                 center;
    int                 off;
    int                 i;
    center = $urandom_range(16, 65519);
    for (i = 0; i < size; i++) begin
      case (mode)
        0: t = TRACK_W'($urandom_range(0, 65535));
        1: begin
          // mirrored around one point so equal distances come up often
          off = $urandom_range(0, 8);
          t = $urandom_range(1) ? TRACK_W'(center + off) : TRACK_W'(center - off);
        end
        default: begin
          case ($urandom_range(4))
            0: t = '0;
            1: t = '1;
            2: t = 16'h0001;
            3: t = 16'hFFFE;
            default: t = 16'h8000;
          endcase
        end
      endcase
      send_request(t, i == size - 1);
    end
  endtask

  initial begin
    int phase;
    int n_batches;
    int size;
    int pick;
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    start_track <= '0;
    in_valid    <= 1'b0;
    track       <= '0;
    last        <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_start(16'h0000);
    send_request(16'h0000, 1'b1);
    send_request(16'hFFFF, 1'b1);
    drain();
    // equal distances from 100: 110 was stored first and goes first
    write_start(16'd100);
    send_request(16'd110, 1'b0);
    send_request(16'd90, 1'b0);
    send_request(16'd80, 1'b0);
    send_request(16'd120, 1'b1);
    send_request(16'd5, 1'b0);
    send_request(16'd5, 1'b0);
    send_request(16'd5, 1'b1);
    drain();
    write_start(16'hFFFF);
    send_request(16'h0000, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'hAAAA, 1'b0);
    send_request(16'h5555, 1'b1);
    send_request(16'h0000, 1'b1);

    phase = 0;
    while (items_sent < N_ITEMS) begin
      drain();
      case (phase % 4)
        0: write_start(16'h0000);
        1: write_start(16'hFFFF);
        default: write_start(TRACK_W'($urandom_range(0, 65535)));
      endcase
      calm = (phase == 1);
      n_batches = $urandom_range(3, 10);
      if (phase == 1) n_batches = 20;
      if (phase == 2) begin
        hold_req  = 1'b1;
        n_batches = 12;
      end
      // full store, and store overflowing with last on a dropped item
      if (phase % 6 == 3) send_batch($urandom_range(65, 70), $urandom_range(2));
      if (phase % 6 == 4) send_batch(64, $urandom_range(2));
      repeat (n_batches) begin
        pick = $urandom_range(99);
        if (phase == 2)     size = $urandom_range(1, 3);
        else if (pick < 3)  size = 64;
        else if (pick < 6)  size = $urandom_range(65, 70);
        else                size = $urandom_range(1, 12);
        send_batch(size, $urandom_range(2));
      end
      phase++;
    end
    calm = 1'b0;
    drain();
    repeat (300) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sstf_pkg.sv
rtl/sstf_cell.sv
rtl/sstf_disk_scheduler_unit.sv
bench/sstf_seek_checker.sv
bench/tb.sv
